[sv/gn2d_pkg.sv]
// Shared types and constants for the 2D gradient-noise core.
`timescale 1ns / 1ps
package gn2d_pkg;
  localparam int PERM_ENTRIES = 256;
  localparam int FRAC_BITS    = 16;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } opcode_t;
endpackage

[sv/gn2d_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module gn2d_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p_r
);
  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

[sv/gradient_noise_2d_core.sv]
// Top level of the 2D gradient-noise core: sequencer, table and blend datapath.
//
// Usage: one input channel (in_*) carries beats of two kinds, selected by
// in_tuser (opcode). Opcode 0 writes in_tdata table_value into the
// permutation table at table_index and yields no result. Opcode 1 samples
// noise at (x_coord, y_coord), both signed Q16.16, and yields one beat on
// the out_* channel holding noise_value (signed, 18 bits).
// A write beat is stored at its accepting edge and leaves the core ready.
// A sample raises out_tvalid in the same cycle that in_tready returns.
// Each of the four corners steps through H1 to H5 (three products on the
// single shared 33x33 multiplier), R1 to R3 (three chained reads of the
// table) and B4 (one gradient pick), then three blends step through B1,
// B2, B3 and OUT each, and SEND loads the output register. The core is not
// ready while a sample is running.
// After reset a clearing pass zeroes all PERM_ENTRIES table entries, one
// entry per cycle, with in_tready low meanwhile.
// A result waits in the output register while the receiver stalls; the
// next sample may be accepted meanwhile but holds in its last step until
// the held beat is taken.
module gradient_noise_2d_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [31:0] x_coord, [63:32] y_coord, [71:64] table_index, [79:72] table_value
  input  logic [79:0]             in_tdata,
  // [0] opcode
  input  gn2d_pkg::opcode_t       in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [17:0] noise_value, zero filled
  output logic [23:0]             out_tdata
);
  import gn2d_pkg::*;

  localparam int IW = $clog2(PERM_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_H1, S_H2, S_H3, S_H4, S_H5, S_R1, S_R2, S_R3,
    S_B1, S_B2, S_B3, S_B4, S_OUT, S_SEND
  } state_t;

  state_t state_r;
  logic [CW-1:0] clr_r;
  logic [1:0] crn_r;
  logic [1:0] blk_r;
  logic [31:0] x_r, y_r, ha_r, hb_r;
  logic [7:0] rd_r;
  logic signed [32:0] d_r [4];
  logic signed [32:0] bla_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [7:0] mem [PERM_ENTRIES];
  logic mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [7:0] mem_wd;
  logic [17:0] out_r;
  logic ov_r;

  // corner lattice coords and offsets
  logic [31:0] lx, ly, cx, cy;
  logic signed [32:0] fx, fy, dx, dy, ba, bb, bt, sh, sum, sat;
  assign lx = 32'($signed(x_r) >>> FRAC_BITS);
  assign ly = 32'($signed(y_r) >>> FRAC_BITS);
  assign fx = 33'(x_r & 32'((64'd1 << FRAC_BITS) - 1));
  assign fy = 33'(y_r & 32'((64'd1 << FRAC_BITS) - 1));
  assign cx = lx + 32'(crn_r[0]);
  assign cy = ly + 32'(crn_r[1]);
  assign dx = crn_r[0] ? fx - ONE : fx;
  assign dy = crn_r[1] ? fy - ONE : fy;

  // blend operands: lo = d0,d1 by fx; hi = d2,d3 by fx; final by fy
  always_comb begin
    case (blk_r)
      2'd0: begin ba = d_r[0]; bb = d_r[1]; bt = fx; end
      2'd1: begin ba = d_r[2]; bb = d_r[3]; bt = fx; end
      default: begin ba = d_r[0]; bb = d_r[2]; bt = fy; end
    endcase
  end

  gn2d_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  // multiplier operand select per state
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_H1: begin ma = {1'b0, cx}; mb = {1'b0, HASH_MUL_A}; end
      S_H3: begin ma = {1'b0, hb_r}; mb = {1'b0, HASH_MUL_B}; end
      S_H5: begin ma = {1'b0, ha_r}; mb = {1'b0, HASH_MUL_C}; end
      S_B1: begin ma = bb - ba; mb = 33'(3) * ONE - (bt <<< 1); end
      S_B2, S_B3: begin ma = sh; mb = bt; end
      default: ;
    endcase
  end

  assign sh  = 33'(prod >>> FRAC_BITS);
  assign sum = sh + bla_r;
  assign sat = (sum > ONE) ? ONE : (sum < -ONE) ? -ONE : sum;

  assign mem_we = (state_r == S_CLEAR) ||
                  (state_r == S_IDLE && in_tvalid && in_tuser == OP_WRITE);
  assign mem_wa = (state_r == S_CLEAR) ? clr_r[IW-1:0] : IW'(in_tdata[71:64]);
  assign mem_wd = (state_r == S_CLEAR) ? 8'd0 : in_tdata[79:72];
  always_comb begin
    case (state_r)
      S_R1: mem_ra = prod[IW-1:0];
      S_R2: mem_ra = IW'(32'(rd_r) + hb_r);
      default: mem_ra = IW'(rd_r);
    endcase
  end

  // permutation table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, out_r};

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (ov_r && out_tready && state_r != S_SEND) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(PERM_ENTRIES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tuser == OP_EVAL) begin
          x_r <= in_tdata[31:0];
          y_r <= in_tdata[63:32];
          crn_r <= 2'd0;
          state_r <= S_H1;
        end
        S_H1: state_r <= S_H2;
        S_H2: begin
          ha_r <= prod[31:0];
          hb_r <= cy ^ {prod[15:0], prod[31:16]};
          state_r <= S_H3;
        end
        S_H3: state_r <= S_H4;
        S_H4: begin
          hb_r <= prod[31:0];
          ha_r <= ha_r ^ {prod[15:0], prod[31:16]};
          state_r <= S_H5;
        end
        S_H5: state_r <= S_R1;
        S_R1: state_r <= S_R2;
        S_R2: state_r <= S_R3;
        S_R3: state_r <= S_B4;
        S_B4: begin
          // rd_r now holds the final entry: pick gradient
          case (rd_r[1:0])
            2'd0: d_r[crn_r] <= dx;
            2'd1: d_r[crn_r] <= -dx;
            2'd2: d_r[crn_r] <= dy;
            default: d_r[crn_r] <= -dy;
          endcase
          crn_r <= crn_r + 2'd1;
          if (crn_r == 2'd3) begin blk_r <= 2'd0; state_r <= S_B1; end
          else state_r <= S_H1;
        end
        S_B1: begin bla_r <= ba; state_r <= S_B2; end
        S_B2: state_r <= S_B3;
        S_B3: state_r <= S_OUT;
        S_OUT: begin
          // lo goes to d0, hi to d2, final result parks in d0
          d_r[blk_r == 2'd1 ? 2'd2 : 2'd0] <= sat;
          if (blk_r == 2'd2) state_r <= S_SEND;
          else begin
            blk_r <= blk_r + 2'd1;
            state_r <= S_B1;
          end
        end
        S_SEND: begin
          if (!ov_r || out_tready) begin
            ov_r <= 1'b1;
            out_r <= d_r[0][17:0];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
